### rtl/bdch_pkg.sv
// Shared types and constants for the button debounce / click / hold unit.
// No dependencies; compiled first.
package bdch_pkg;

    // Default width of the internal timestamp arithmetic
    localparam int TIME_BITS_DFLT = 32;

    // Field widths fixed by the word format
    localparam int NOW_W   = 32;
    localparam int CFG_W   = 16;
    localparam int STATE_W = 2;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 1'b0,
        REG_HOLD     = 1'b1
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] HOLD_RST     = 16'd1000;

    typedef enum logic [STATE_W-1:0] {
        ST_RELEASED = 2'd0,
        ST_PRESSED  = 2'd1,
        ST_HELD     = 2'd2
    } press_state_t;

    // Control state carried from one word to the next
    typedef struct packed {
        press_state_t state;
        logic         armed;
    } bdch_ctrl_t;

    // Programmed timeouts
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] hold_ms;
    } bdch_cfg_t;

endpackage

### rtl/bdch_if.sv
// Valid/ready stream interfaces for the sample and result words.
// Depends on bdch_pkg for field widths.
interface bdch_in_if;
    import bdch_pkg::*;

    logic             valid;
    logic             ready;
    logic             pin_level;
    logic [NOW_W-1:0] now_ms;

    modport source (output valid, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bdch_out_if;
    import bdch_pkg::*;

    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] button_state;
    logic               clicked;

    modport source (output valid, output button_state, output clicked, input ready);
    modport sink   (input valid, input button_state, input clicked, output ready);
endinterface

### rtl/bdch_step.sv
// Next-state logic for one pin sample: debounce, click and hold decisions.
// Depends on bdch_pkg; purely combinational.
module bdch_step #(
    parameter int TIME_BITS = bdch_pkg::TIME_BITS_DFLT
) (
    input  logic                  pin_level,
    input  logic [TIME_BITS-1:0]  now,
    input  bdch_pkg::bdch_ctrl_t  ctrl,
    input  logic [TIME_BITS-1:0]  start,
    input  bdch_pkg::bdch_cfg_t   cfg,
    output bdch_pkg::bdch_ctrl_t  ctrl_next,
    output logic [TIME_BITS-1:0]  start_next,
    output logic                  clicked
);
    import bdch_pkg::*;

    logic                 pressed;
    logic [TIME_BITS-1:0] elapsed;
    logic                 debounce_done;
    logic                 hold_done;

    assign pressed       = ~pin_level;
    assign elapsed       = now - start;     // wraps modulo 2^TIME_BITS
    assign debounce_done = elapsed >= TIME_BITS'(cfg.debounce_ms);
    assign hold_done     = elapsed >= TIME_BITS'(cfg.hold_ms);

    // A click only lives until it is reported, which is this same word
    assign clicked = ~pressed && (ctrl.state == ST_PRESSED);

    always_comb
    begin
        ctrl_next  = ctrl;
        start_next = start;

        if (pressed)
        begin
            unique case (ctrl.state)
                ST_RELEASED:
                begin
                    if (!ctrl.armed)
                    begin
                        ctrl_next.armed = 1'b1;
                        start_next      = now;
                    end
                    else if (debounce_done)
                    begin
                        ctrl_next.state = hold_done ? ST_HELD : ST_PRESSED;
                    end
                end
                ST_PRESSED:
                begin
                    if (hold_done)
                        ctrl_next.state = ST_HELD;
                end
                ST_HELD:
                begin
                    ctrl_next.state = ST_HELD;
                end
                default:
                begin
                    ctrl_next.state = ctrl.state;
                end
            endcase
        end
        else if (ctrl.state != ST_RELEASED)
        begin
            ctrl_next.armed = 1'b0;
            ctrl_next.state = ST_RELEASED;
        end
    end

endmodule

### rtl/button_debounce_click_hold_unit.sv
// Top level of the push-button debouncer with click and long-press detection.
// Depends on bdch_pkg, bdch_if (bdch_in_if, bdch_out_if) and bdch_step.
//
// Each sample word carries the raw active-low pin level and a wrapping
// millisecond timestamp; each accepted sample yields exactly one result word
// with the state after that sample (released, pressed, held) and a click
// flag that is set once, on the release that ends a press that never
// reached hold. A press counts after it has stayed low for debounce_ms,
// measured from the first low sample after release, and it always needs a
// second low sample; it becomes held once hold_ms have passed since that
// first sample, possibly in the same word. Timestamps are compared modulo
// 2^TIME_BITS. The block takes one sample per clock unless the result stalls;
// a sample passes an input register, then the decision logic into the result
// register, which is where the debounce state is updated. A stalled result
// holds both stages; a new sample is still taken whenever the result register
// is free or being emptied in that cycle. Timeouts must be written through the
// plain configuration port while no word is in flight; not enforced here.
module button_debounce_click_hold_unit #(
    parameter int TIME_BITS = bdch_pkg::TIME_BITS_DFLT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bdch_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdch_pkg::CFG_W-1:0]    cfg_wdata,
    bdch_in_if.sink                       sample,
    bdch_out_if.source                    result
);
    import bdch_pkg::*;

    // Bits of now_ms that take part in time arithmetic
    localparam int NOW_KEEP = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;

    // Configuration
    bdch_cfg_t cfg_reg;

    // Input stage
    logic                 in_vld_reg;
    logic                 in_pin_reg;
    logic [TIME_BITS-1:0] in_now_reg;

    // Debounce state
    bdch_ctrl_t           ctrl_reg;
    bdch_ctrl_t           ctrl_next;
    logic [TIME_BITS-1:0] start_reg;
    logic [TIME_BITS-1:0] start_next;

    // Result stage
    logic                 out_vld_reg;
    press_state_t         out_state_reg;
    logic                 out_click_reg;
    logic                 click_next;

    logic                 advance;      // input stage moves into the result stage
    logic                 take;         // sample word accepted

    assign advance      = ~out_vld_reg | result.ready;
    assign sample.ready = ~in_vld_reg | advance;
    assign take         = sample.valid & sample.ready;

    assign result.valid        = out_vld_reg;
    assign result.button_state = out_state_reg;
    assign result.clicked      = out_click_reg;

    // ---------------------------------------------------------------
    // Configuration registers; an index outside the map is ignored
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms <= DEBOUNCE_RST;
            cfg_reg.hold_ms     <= HOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DEBOUNCE: cfg_reg.debounce_ms <= cfg_wdata;
                REG_HOLD:     cfg_reg.hold_ms     <= cfg_wdata;
                default:      cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (sample.ready)
            in_vld_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_pin_reg <= sample.pin_level;
            in_now_reg <= TIME_BITS'(sample.now_ms[NOW_KEEP-1:0]);
        end
    end

    // ---------------------------------------------------------------
    // Decision logic
    // ---------------------------------------------------------------
    bdch_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .pin_level  (in_pin_reg),
        .now        (in_now_reg),
        .ctrl       (ctrl_reg),
        .start      (start_reg),
        .cfg        (cfg_reg),
        .ctrl_next  (ctrl_next),
        .start_next (start_next),
        .clicked    (click_next)
    );

    // ---------------------------------------------------------------
    // State and result registers; updated once per word that advances
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.state <= ST_RELEASED;
            ctrl_reg.armed <= 1'b0;
            start_reg      <= '0;
            out_vld_reg    <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
            if (in_vld_reg)
            begin
                ctrl_reg  <= ctrl_next;
                start_reg <= start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_vld_reg)
        begin
            out_state_reg <= ctrl_next.state;
            out_click_reg <= click_next;
        end
    end

endmodule

### tb/button_debounce_click_hold_unit_tb.sv
// Self-checking testbench for button_debounce_click_hold_unit: sample words in, state/click
// words out, each checked against a cycle-free debounce predictor kept in the bench.
// Depends on bdch_pkg and the bdch_in_if / bdch_out_if stream interfaces.
module button_debounce_click_hold_unit_tb;
    import bdch_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 4;
    // Two pipeline stages; a few spare cycles before touching the timeouts
    localparam int DRAIN_CYCLES = 6;
    // Bound for roughly 1000 words at worst-case gaps and stalls
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;

    // One expected result word
    typedef struct {
        press_state_t state;
        logic         clicked;
    } button_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    bdch_in_if  sample_if ();
    bdch_out_if result_if ();

    button_debounce_click_hold_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (sample_if),
        .result    (result_if)
    );

    always #CLK_HALF clk = ~clk;

    // Predictor state: a shadow of the debouncer and of its two timeouts
    logic [CFG_W-1:0] mdl_debounce;
    logic [CFG_W-1:0] mdl_hold;
    press_state_t     mdl_state;
    logic             mdl_armed;
    logic [NOW_W-1:0] mdl_start;
    logic             mdl_click;

    button_report_t   report_q[$];      // expected words, oldest first
    int               mismatch_cnt = 0;
    int               cycle_cnt    = 0;
    int               words_sent   = 0;
    logic [NOW_W-1:0] stamp_ms     = '0; // running millisecond stamp for sessions

    // Idling controls, shared between the test thread and the two drivers
    bit               tx_idle_en   = 1'b0;
    bit               rx_idle_en   = 1'b0;
    int               rx_hold_req  = 0;  // request a long receiver hold-off, in cycles

    // Mostly no gap, now and then a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void flag_error(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
            $display("ERROR @%0t: %s", $time, msg);
    endfunction

    // Advance the shadow debouncer by one sample and queue the word it must report.
    // Elapsed time is taken once up front: the start stamp only moves on the arming
    // sample, and that sample leaves the state released, so neither threshold is
    // tested against the new stamp in the same step.
    function automatic void predict_button_report(input logic pin, input logic [NOW_W-1:0] now);
        logic             pressed;
        logic [NOW_W-1:0] since_start;
        button_report_t   rep;
        pressed     = ~pin;
        since_start = now - mdl_start;   // wraps modulo 2^32 like the stamp itself
        if (pressed && mdl_state == ST_RELEASED)
        begin
            if (!mdl_armed)
            begin
                // first low sample after release: arm, note start, drop any stale click
                mdl_armed = 1'b1;
                mdl_start = now;
                mdl_click = 1'b0;
            end
            else if (since_start >= mdl_debounce)
            begin
                mdl_state = ST_PRESSED;
            end
        end
        if (!pressed && mdl_state != ST_RELEASED)
        begin
            mdl_armed = 1'b0;
            if (mdl_state == ST_PRESSED)
                mdl_click = 1'b1;    // short press ends in a click, a held one does not
            mdl_state = ST_RELEASED;
        end
        if (mdl_state == ST_PRESSED && since_start >= mdl_hold)
            mdl_state = ST_HELD;
        rep.state   = mdl_state;
        rep.clicked = mdl_click;
        mdl_click   = 1'b0;          // read-to-clear
        report_q.push_back(rep);
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Inputs move on the falling edge; acceptance is seen on
    // the rising edge. valid is left high after a word so that back-to-back
    // words can follow directly; whoever comes next lowers or reloads it.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic pin, input logic [NOW_W-1:0] now);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            sample_if.valid <= 1'b0;
        end
        @(negedge clk);
        sample_if.valid     <= 1'b1;
        sample_if.pin_level <= pin;
        sample_if.now_ms    <= now;
        do
            @(posedge clk);
        while (sample_if.ready !== 1'b1);
        predict_button_report(pin, now);
        words_sent++;
    endtask

    // Move the stamp forward by dt ms, then send
    task automatic send_after(input logic pin, input int unsigned dt);
        stamp_ms += dt;
        send_sample(pin, stamp_ms);
    endtask

    // Stop offering words and wait for every expected word, plus the pipeline tail
    task automatic wait_drain();
        @(negedge clk);
        sample_if.valid <= 1'b0;
        while (report_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Only called with the block idle
    task automatic write_timeout(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_DEBOUNCE: mdl_debounce = value;
            REG_HOLD:     mdl_hold     = value;
            default:      ;
        endcase
    endtask

    task automatic set_timeouts(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hold);
        write_timeout(REG_DEBOUNCE, deb);
        write_timeout(REG_HOLD, hold);
    endtask

    // One plausible press: some contact bounce, a low stretch that may
    // cross debounce and perhaps hold, then a release with one to three samples.
    task automatic press_session(input int span, input int deb);
        int bounces;
        int lows;
        int highs;
        bounces = $urandom_range(0, 3);
        lows    = $urandom_range(1, 10);
        highs   = $urandom_range(1, 3);
        repeat (bounces)
        begin
            send_after(1'b0, $urandom_range(0, deb / 4 + 1));
            send_after(1'b1, $urandom_range(0, deb / 4 + 1));
        end
        repeat (lows) send_after(1'b0, $urandom_range(0, span));
        repeat (highs) send_after(1'b1, $urandom_range(0, span));
    endtask

    // ------------------------------------------------------------------
    // Receiver side: sole driver of result ready. Random stalls when
    // enabled, and a long hold-off counted here when the test asks for one.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int hold_left;
        int stall_left;
        hold_left       = 0;
        stall_left      = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left == 0 && stall_left == 0 && rx_idle_en)
                stall_left = pick_gap();
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready_low: result_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Every accepted result word is held against the oldest expectation
    always @(posedge clk)
    begin : check_results
        button_report_t want;
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (report_q.size() == 0)
            begin
                flag_error($sformatf("unexpected word: state=%0d clicked=%b",
                                     result_if.button_state, result_if.clicked));
            end
            else
            begin
                want = report_q.pop_front();
                if (result_if.button_state !== want.state || result_if.clicked !== want.clicked)
                    flag_error($sformatf("word mismatch: state exp %0d got %0d, clicked exp %b got %b",
                                         want.state, result_if.button_state,
                                         want.clicked, result_if.clicked));
            end
        end
    end

    // Watchdog against a hung handshake or a word that never comes
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset timeouts (50 / 1000 ms): plain click, bounce while armed, and a
    // late sample that jumps straight to held and releases without a click
    task automatic test_reset_defaults();
        send_sample(1'b1, 32'd0);
        send_sample(1'b0, 32'd100);     // arms, start = 100
        send_sample(1'b0, 32'd149);     // one ms short of debounce
        send_sample(1'b0, 32'd150);     // pressed
        send_sample(1'b1, 32'd200);     // release -> click
        send_sample(1'b1, 32'd210);     // click already reported
        send_sample(1'b0, 32'd300);     // arms again
        send_sample(1'b1, 32'd310);     // bounce: stays armed, start kept
        send_sample(1'b0, 32'd1400);    // pressed and held in one step
        send_sample(1'b1, 32'd1500);    // release from held, no click
        wait_drain();
    endtask

    // Timeout extremes and stamp wrap
    task automatic test_timer_extremes();
        // Zero debounce still needs a second low sample; hold at maximum across the wrap
        set_timeouts(16'd0, 16'hFFFF);
        send_sample(1'b0, 32'hFFFF_FFF0);
        send_sample(1'b0, 32'hFFFF_FFF0);
        send_sample(1'b0, 32'h0000_FFEE);   // elapsed 0xFFFE
        send_sample(1'b0, 32'h0000_FFEF);   // elapsed 0xFFFF -> held
        send_sample(1'b1, 32'h0000_FFF0);
        wait_drain();
        // Maximum debounce with zero hold: pressed is never seen, only held
        set_timeouts(16'hFFFF, 16'd0);
        send_sample(1'b0, 32'd5);
        send_sample(1'b0, 32'h0001_0003);
        send_sample(1'b0, 32'h0001_0004);
        send_sample(1'b1, 32'hFFFF_FFFF);
        wait_drain();
        // Fresh press straight after a click
        set_timeouts(16'd0, 16'd1000);
        send_sample(1'b0, 32'd10);
        send_sample(1'b0, 32'd10);
        send_sample(1'b1, 32'd11);
        send_sample(1'b0, 32'd12);
        send_sample(1'b1, 32'd13);
        wait_drain();
    endtask

    // Receiver holds off for a long stretch while words keep coming, so the
    // block fills and stalls its input; then the sender pauses until all is
    // through, and carries on from an empty pipeline
    task automatic test_output_stall();
        int i;
        set_timeouts(16'd2, 16'd20);
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        rx_hold_req = 60;
        for (i = 0; i < 24; i++)
            send_after((i % 6) >= 4, $urandom_range(1, 8));
        wait_drain();
        for (i = 0; i < 6; i++)
            send_after(i == 5, $urandom_range(1, 12));
        wait_drain();
    endtask

    // Random phase at one timeout setting: mostly press sessions with random
    // timing, some raw noise words, stamp jumps toward the wrap, and pauses
    task automatic test_random_phase(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hold,
                                     input int n_words);
        int first;
        int span;
        set_timeouts(deb, hold);
        span  = (int'(deb) + int'(hold)) / 4 + 2;
        first = words_sent;
        while (words_sent - first < n_words)
        begin
            // each side runs about three sessions in ten with no idling, drawn independently
            tx_idle_en = ($urandom_range(0, 9) < 7);
            rx_idle_en = ($urandom_range(0, 9) < 7);
            case ($urandom_range(0, 19))
                0:
                begin
                    repeat ($urandom_range(1, 4))
                        send_sample(1'($urandom_range(0, 1)), $urandom);
                    stamp_ms = $urandom;
                end
                1: stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, span * 4);
                2: wait_drain();
                default: press_session(span, int'(deb));
            endcase
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = REG_DEBOUNCE;
        cfg_wdata           = '0;
        sample_if.valid     = 1'b0;
        sample_if.pin_level = 1'b1;
        sample_if.now_ms    = '0;
        mdl_debounce        = DEBOUNCE_RST;
        mdl_hold            = HOLD_RST;
        mdl_state           = ST_RELEASED;
        mdl_armed           = 1'b0;
        mdl_start           = '0;
        mdl_click           = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_timer_extremes();
        test_output_stall();
        test_random_phase(16'd0, 16'd0, 150);
        test_random_phase(16'hFFFF, 16'hFFFF, 150);
        test_random_phase(16'd3, 16'd40, 150);
        test_random_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 150);
        test_random_phase(16'd50, 16'd1000, 150);
        test_random_phase(16'($urandom_range(0, 30)), 16'($urandom_range(0, 300)), 150);

        if (mismatch_cnt == 0 && report_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
rtl/bdch_pkg.sv
rtl/bdch_if.sv
rtl/bdch_step.sv
rtl/button_debounce_click_hold_unit.sv
tb/button_debounce_click_hold_unit_tb.sv
